@@ hdl/pdu_pkg.sv @@
// Package of the periodic displacement unit: widths, table offsets,
// micro-operation codes and the controller/datapath interface structs.
// Depends on nothing.
package pdu_pkg;

	localparam int MAX_WRAP_STEPS_DEF = 16;
	localparam int POS_FRAC_BITS_DEF  = 16;

	localparam int NUM_COEF = 48;
	localparam logic [5:0] CUR_MAT = 6'd0;
	localparam logic [5:0] CUR_INV = 6'd12;
	localparam logic [5:0] REF_MAT = 6'd24;
	localparam logic [5:0] REF_INV = 6'd36;

	localparam logic [1:0] REG_USE_MIN_IMAGE = 2'd0;
	localparam logic [1:0] REG_PBC_MASK      = 2'd1;
	localparam logic [1:0] REG_MAPPING_MODE  = 2'd2;

	localparam logic [1:0] MODE_DIRECT = 2'd0;
	localparam logic [1:0] MODE_REF    = 2'd1;

	localparam int VW = 60;
	localparam int AW = 96;
	localparam int MA = 34;
	localparam int MB = 33;
	localparam int PW = MA + MB;
	localparam int CW = 33;

	typedef enum logic [4:0] {
		MOP_NOP, MOP_FWD, MOP_TRN, MOP_BLO, MOP_BHI, MOP_SLO, MOP_SHI, MOP_CC,
		MOP_SQ, MOP_ST_D, MOP_ST_RES, MOP_LD_C, MOP_INIT_U, MOP_APPLY,
		MOP_DRES, MOP_ST_SQ, MOP_SQRT, MOP_HIT
	} mop_t;

	typedef struct packed {
		mop_t       mop;
		logic [5:0] addr;
		logic [1:0] idx;
		logic       first;
		logic       neg;
		logic       wrap;
	} cmd_t;

	typedef struct packed {
		logic capture;
		logic ram_we;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		logic acc_neg;
	} sts_t;

endpackage

@@ hdl/pdu_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module pdu_ram #(
	parameter int W = 32,
	parameter int D = 48
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/pdu_datapath.sv @@
// Datapath: coefficient RAM, shared multiplier, wide accumulator, vector
// registers, square root iteration and output register. Uses pdu_pkg, pdu_ram.
module pdu_datapath
	import pdu_pkg::*;
#(
	parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	input  ctl_t         ctl,
	input  logic [231:0] in_data,
	output sts_t         sts,
	output logic [135:0] out_data
);

	localparam logic [VW-1:0] HALF = VW'(1) << (POS_FRAC_BITS + 15);
	localparam logic [VW-1:0] MASK = (VW'(1) << (POS_FRAC_BITS + 16)) - VW'(1);

	cmd_t cmd_s1, cmd_s2;
	logic [31:0] rdata;
	logic signed [31:0] coef_s2;
	logic signed [PW-1:0] prod_s2;
	logic signed [AW-1:0] acc_q;
	logic signed [31:0] pc_q [3];
	logic signed [31:0] pr_q [3];
	logic signed [VW-1:0] dvec_q [3];
	logic signed [CW-1:0] cvec_q [3];
	logic signed [31:0] res_q [3];
	logic sat_q, hit_q;
	logic [63:0] sq_v_q, sq_r_q, sq_b_q;
	logic [135:0] out_q;

	logic signed [MA-1:0] ma;
	logic signed [MB-1:0] mb;
	logic signed [32:0] r33, rabs;
	logic signed [AW-1:0] prodx, coefx, term, accn;
	logic [VW-1:0] wt, wv;
	logic [63:0] rb;
	logic signed [CW-1:0] cx;
	logic [2:0] dfit;

	pdu_ram #(.W(32), .D(NUM_COEF)) u_ram (
		.clk(clk),
		.we(ctl.ram_we),
		.waddr(in_data[5:0]),
		.wdata(in_data[37:6]),
		.raddr(cmd.addr),
		.rdata(rdata)
	);

	always_comb begin
		r33 = {res_q[cmd_s1.idx][31], res_q[cmd_s1.idx]};
		rabs = r33[32] ? -r33 : r33;
		ma = '0;
		mb = '0;
		case (cmd_s1.mop)
			MOP_FWD: begin
				ma = cmd_s1.neg ? MA'(pr_q[cmd_s1.idx]) : MA'(pc_q[cmd_s1.idx]);
				mb = MB'($signed(rdata));
			end
			MOP_BLO: begin
				ma = {{(MA-30){1'b0}}, dvec_q[cmd_s1.idx][29:0]};
				mb = MB'($signed(rdata));
			end
			MOP_BHI: begin
				ma = MA'($signed(dvec_q[cmd_s1.idx][VW-1:30]));
				mb = MB'($signed(rdata));
			end
			MOP_SLO: begin
				ma = {{(MA-30){1'b0}}, dvec_q[cmd_s1.idx][29:0]};
				mb = cmd_s1.neg ? -cvec_q[cmd_s1.idx] : cvec_q[cmd_s1.idx];
			end
			MOP_SHI: begin
				ma = MA'($signed(dvec_q[cmd_s1.idx][VW-1:30]));
				mb = cmd_s1.neg ? -cvec_q[cmd_s1.idx] : cvec_q[cmd_s1.idx];
			end
			MOP_CC: begin
				ma = MA'(cvec_q[cmd_s1.idx]);
				mb = cvec_q[cmd_s1.idx];
			end
			MOP_SQ: begin
				ma = MA'(rabs);
				mb = rabs;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		prodx = AW'(prod_s2);
		coefx = AW'(coef_s2);
		case (cmd_s2.mop)
			MOP_FWD: term = prodx >>> 8;
			MOP_TRN: term = coefx <<< (POS_FRAC_BITS - 8);
			MOP_BHI: term = prodx <<< 30;
			MOP_SLO: term = prodx <<< 1;
			MOP_SHI: term = prodx <<< 31;
			default: term = prodx;
		endcase
		if (cmd_s2.neg && (cmd_s2.mop == MOP_FWD || cmd_s2.mop == MOP_TRN)) begin
			term = -term;
		end
		accn = (cmd_s2.first ? AW'(0) : acc_q) + term;
		wt = acc_q[VW-1:0] + HALF;
		wv = (wt & MASK) - HALF;
		rb = sq_r_q + sq_b_q;
		cx = {coef_s2[31], coef_s2};
		for (int i = 0; i < 3; i++) begin
			dfit[i] = (&dvec_q[i][VW-1:31]) || !(|dvec_q[i][VW-1:31]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '0;
			cmd_s2 <= '0;
		end else begin
			cmd_s1 <= cmd;
			cmd_s2 <= cmd_s1;
		end
	end

	always_ff @(posedge clk) begin
		coef_s2 <= $signed(rdata);
		prod_s2 <= ma * mb;
		if (ctl.capture) begin
			for (int i = 0; i < 3; i++) begin
				pc_q[i] <= $signed(in_data[38 + 32*i +: 32]);
				pr_q[i] <= $signed(in_data[134 + 32*i +: 32]);
			end
			sat_q <= 1'b0;
			hit_q <= 1'b0;
		end
		case (cmd_s2.mop)
			MOP_FWD, MOP_TRN, MOP_BLO, MOP_BHI, MOP_SLO, MOP_SHI, MOP_CC,
			MOP_SQ: begin
				acc_q <= accn;
			end
			MOP_ST_D: begin
				dvec_q[cmd_s2.idx] <= cmd_s2.wrap ? $signed(wv) : acc_q[VW-1:0];
			end
			MOP_ST_RES: begin
				if ((&acc_q[AW-1:71]) || !(|acc_q[AW-1:71])) begin
					res_q[cmd_s2.idx] <= acc_q[71:40];
				end else begin
					res_q[cmd_s2.idx] <= acc_q[AW-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
					sat_q <= 1'b1;
				end
			end
			MOP_LD_C: begin
				cvec_q[cmd_s2.idx] <= cx >>> (24 - POS_FRAC_BITS);
			end
			MOP_INIT_U: begin
				for (int i = 0; i < 3; i++) begin
					dvec_q[i] <= VW'(pc_q[i]) - VW'(pr_q[i]);
				end
			end
			MOP_APPLY: begin
				for (int i = 0; i < 3; i++) begin
					dvec_q[i] <= cmd_s2.neg ? dvec_q[i] - VW'(cvec_q[i])
						: dvec_q[i] + VW'(cvec_q[i]);
				end
			end
			MOP_DRES: begin
				for (int i = 0; i < 3; i++) begin
					if (dfit[i]) begin
						res_q[i] <= dvec_q[i][31:0];
					end else begin
						res_q[i] <= dvec_q[i][VW-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
					end
				end
				if (!(&dfit)) begin
					sat_q <= 1'b1;
				end
			end
			MOP_ST_SQ: begin
				sq_v_q <= acc_q[63:0];
				sq_r_q <= '0;
				sq_b_q <= 64'h4000_0000_0000_0000;
			end
			MOP_SQRT: begin
				if (sq_v_q >= rb) begin
					sq_v_q <= sq_v_q - rb;
					sq_r_q <= (sq_r_q >> 1) + sq_b_q;
				end else begin
					sq_r_q <= sq_r_q >> 1;
				end
				sq_b_q <= sq_b_q >> 2;
			end
			MOP_HIT: begin
				hit_q <= 1'b1;
			end
			default: begin
			end
		endcase
		if (ctl.out_load) begin
			out_q <= {6'd0, sat_q, hit_q, sq_r_q[31:0], res_q[2], res_q[1], res_q[0]};
		end
	end

	assign sts.acc_neg = acc_q[AW-1];
	assign out_data = out_q;

endmodule

@@ hdl/pdu_ctrl.sv @@
// Controller: configuration registers, handshakes and the sequencer that
// issues one datapath command per cycle. Uses pdu_pkg.
module pdu_ctrl
	import pdu_pkg::*;
#(
	parameter int MAX_WRAP_STEPS = MAX_WRAP_STEPS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_valid,
	input  logic       s_op,
	input  logic [5:0] s_idx,
	output logic       s_ready,
	input  logic       cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [2:0] cfg_data,
	output logic       cfg_ready,
	output logic       m_valid,
	input  logic       m_ready,
	input  sts_t       sts,
	output cmd_t       cmd,
	output ctl_t       ctl
);

	localparam int SW = $clog2(MAX_WRAP_STEPS + 1);

	typedef enum logic [11:0] {
		ST_IDLE   = 12'b000000000001,
		ST_FWD    = 12'b000000000010,
		ST_BACK   = 12'b000000000100,
		ST_AXIS   = 12'b000000001000,
		ST_LDC    = 12'b000000010000,
		ST_TEST   = 12'b000000100000,
		ST_DECIDE = 12'b000001000000,
		ST_DRES   = 12'b000010000000,
		ST_SQ     = 12'b000100000000,
		ST_SQRT   = 12'b001000000000,
		ST_WAIT   = 12'b010000000000,
		ST_DONE   = 12'b100000000000
	} state_t;

	state_t state_q, ret_q;
	cmd_t cmd_q;
	logic use_q;
	logic [2:0] pbc_q;
	logic [1:0] mode_q;
	logic [4:0] j_q;
	logic [1:0] k_q, i_q, ph_q, wcnt_q;
	logic [SW-1:0] steps_q;
	logic dir_q, out_valid_q;
	logic accept;
	logic [5:0] row;
	logic [5:0] back_base;

	assign s_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept = s_valid && s_ready;
	assign ctl.capture = accept && !s_op;
	assign ctl.ram_we = accept && s_op && (s_idx < 6'(NUM_COEF));
	assign ctl.out_load = (state_q == ST_DONE) && (!out_valid_q || m_ready);
	assign m_valid = out_valid_q;
	assign cmd = cmd_q;
	assign row = {2'b00, k_q, 2'b00};
	assign back_base = (mode_q == MODE_REF) ? REF_MAT : CUR_MAT;

	always_ff @(posedge clk or negedge arst_n) begin
		cmd_t cmd_n;
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			cmd_q <= '0;
			use_q <= 1'b1;
			pbc_q <= 3'd7;
			mode_q <= MODE_DIRECT;
			j_q <= '0;
			k_q <= '0;
			i_q <= '0;
			ph_q <= '0;
			wcnt_q <= '0;
			steps_q <= '0;
			dir_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cmd_n = '0;
			if (cfg_valid) begin
				case (cfg_index)
					REG_USE_MIN_IMAGE: use_q <= cfg_data[0];
					REG_PBC_MASK:      pbc_q <= cfg_data;
					REG_MAPPING_MODE:  mode_q <= cfg_data[1:0];
					default: begin
					end
				endcase
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (ctl.capture) begin
						j_q <= '0;
						k_q <= '0;
						if (mode_q != MODE_DIRECT) begin
							state_q <= ST_FWD;
						end else begin
							cmd_n.mop = MOP_INIT_U;
							if (use_q) begin
								state_q <= ST_AXIS;
							end else begin
								state_q <= ST_DRES;
							end
						end
					end
				end
				ST_FWD: begin
					if (j_q == 5'd8) begin
						cmd_n.mop = MOP_ST_D;
						cmd_n.idx = k_q;
						cmd_n.wrap = use_q && pbc_q[k_q];
						j_q <= '0;
						if (k_q == 2'd2) begin
							k_q <= '0;
							ret_q <= ST_BACK;
							wcnt_q <= 2'd2;
							state_q <= ST_WAIT;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end else begin
						cmd_n.mop = (j_q[1:0] == 2'd3) ? MOP_TRN : MOP_FWD;
						cmd_n.addr = (j_q[2] ? REF_INV : CUR_INV) + row + 6'(j_q[1:0]);
						cmd_n.idx = j_q[1:0];
						cmd_n.neg = j_q[2];
						cmd_n.first = (j_q == 5'd0);
						j_q <= j_q + 5'd1;
					end
				end
				ST_BACK: begin
					if (j_q == 5'd6) begin
						cmd_n.mop = MOP_ST_RES;
						cmd_n.idx = k_q;
						j_q <= '0;
						if (k_q == 2'd2) begin
							k_q <= '0;
							ret_q <= ST_SQ;
							wcnt_q <= 2'd2;
							state_q <= ST_WAIT;
						end else begin
							k_q <= k_q + 2'd1;
						end
					end else begin
						cmd_n.mop = j_q[0] ? MOP_BHI : MOP_BLO;
						cmd_n.addr = back_base + row + 6'(j_q[2:1]);
						cmd_n.idx = j_q[2:1];
						cmd_n.first = (j_q == 5'd0);
						j_q <= j_q + 5'd1;
					end
				end
				ST_AXIS: begin
					if (pbc_q[k_q]) begin
						j_q <= '0;
						state_q <= ST_LDC;
					end else if (k_q == 2'd2) begin
						state_q <= ST_DRES;
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				ST_LDC: begin
					cmd_n.mop = MOP_LD_C;
					cmd_n.idx = j_q[1:0];
					cmd_n.addr = REF_MAT + {2'b00, j_q[1:0], 2'b00} + {4'd0, k_q};
					if (j_q == 5'd2) begin
						j_q <= '0;
						steps_q <= '0;
						dir_q <= 1'b0;
						i_q <= '0;
						ph_q <= '0;
						ret_q <= ST_TEST;
						wcnt_q <= 2'd2;
						state_q <= ST_WAIT;
					end else begin
						j_q <= j_q + 5'd1;
					end
				end
				ST_TEST: begin
					case (ph_q)
						2'd0: cmd_n.mop = MOP_SLO;
						2'd1: cmd_n.mop = MOP_SHI;
						default: cmd_n.mop = MOP_CC;
					endcase
					cmd_n.idx = i_q;
					cmd_n.neg = dir_q;
					cmd_n.first = (i_q == 2'd0) && (ph_q == 2'd0);
					if (ph_q == 2'd2) begin
						ph_q <= '0;
						if (i_q == 2'd2) begin
							i_q <= '0;
							ret_q <= ST_DECIDE;
							wcnt_q <= 2'd2;
							state_q <= ST_WAIT;
						end else begin
							i_q <= i_q + 2'd1;
						end
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				ST_DECIDE: begin
					if (sts.acc_neg && (steps_q < SW'(MAX_WRAP_STEPS))) begin
						cmd_n.mop = MOP_APPLY;
						cmd_n.neg = dir_q;
						steps_q <= steps_q + SW'(1);
						ret_q <= ST_TEST;
						wcnt_q <= 2'd2;
						state_q <= ST_WAIT;
					end else begin
						if (sts.acc_neg) begin
							cmd_n.mop = MOP_HIT;
						end
						if (!dir_q) begin
							dir_q <= 1'b1;
							state_q <= ST_TEST;
						end else if (k_q == 2'd2) begin
							state_q <= ST_DRES;
						end else begin
							k_q <= k_q + 2'd1;
							state_q <= ST_AXIS;
						end
					end
				end
				ST_DRES: begin
					cmd_n.mop = MOP_DRES;
					j_q <= '0;
					ret_q <= ST_SQ;
					wcnt_q <= 2'd2;
					state_q <= ST_WAIT;
				end
				ST_SQ: begin
					if (j_q == 5'd3) begin
						cmd_n.mop = MOP_ST_SQ;
						j_q <= '0;
						state_q <= ST_SQRT;
					end else begin
						cmd_n.mop = MOP_SQ;
						cmd_n.idx = j_q[1:0];
						cmd_n.first = (j_q == 5'd0);
						j_q <= j_q + 5'd1;
					end
				end
				ST_SQRT: begin
					cmd_n.mop = MOP_SQRT;
					j_q <= j_q + 5'd1;
					if (j_q == 5'd31) begin
						ret_q <= ST_DONE;
						wcnt_q <= 2'd2;
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					wcnt_q <= wcnt_q - 2'd1;
					if (wcnt_q == 2'd0) begin
						state_q <= ret_q;
					end
				end
				ST_DONE: begin
					if (ctl.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			cmd_q <= cmd_n;
		end
	end

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT || state_q == ST_TEST) |-> !s_ready)
		else $error("input accepted while an item is in progress");

	a_steps_bound: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= SW'(MAX_WRAP_STEPS))
		else $error("wrap step counter beyond its bound");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result load did not raise valid");

	a_capture_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |=> (state_q != ST_IDLE))
		else $error("compute word accepted but sequencer stayed idle");

endmodule

@@ hdl/periodic_displacement_unit.sv @@
// Top level of the periodic displacement unit: stream ports, configuration
// port, controller and datapath. Uses pdu_pkg, pdu_ctrl, pdu_datapath.
//
// Input words arrive on the s_axis channel. tuser carries op: a load word
// (op 1) writes one cell coefficient, if its index is below NUM_COEF, in the
// cycle it is accepted and makes no result; a compute word (op 0) produces
// exactly one result word on the m_axis channel. Configuration is written
// through cfg_valid/cfg_index/cfg_data; the user must write it only while
// the unit is idle, as the block itself does not enforce this. cfg_ready is
// always high. Wrapping applies at most MAX_WRAP_STEPS column steps per axis.
// A single shared multiplier carries the transform products and the test and
// square terms, and the square root is a 32-step bit-serial iteration. The
// next word is accepted from the cycle the result is presented; a load word
// leaves the sequencer idle. The finished result sits in an output register
// while the next word runs; a stalled receiver holds that word, and a
// following result then waits in the sequencer, with the input blocked,
// until the held word is taken.
// Reset returns the registers to their defaults and the sequencer to idle;
// coefficients are undefined until loaded.
module periodic_displacement_unit
	import pdu_pkg::*;
#(
	parameter int MAX_WRAP_STEPS = MAX_WRAP_STEPS_DEF,
	parameter int POS_FRAC_BITS  = POS_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// coef_index, coef_value, cur_x, cur_y, cur_z, ref_x, ref_y, ref_z, 2 zero bits
	input  logic [231:0] s_axis_tdata,
	// op
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// disp_x, disp_y, disp_z, disp_magnitude, wrap_limit_hit, saturated, 6 zero bits
	output logic [135:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [2:0]   cfg_data
);

	cmd_t cmd;
	ctl_t ctl;
	sts_t sts;

	pdu_ctrl #(.MAX_WRAP_STEPS(MAX_WRAP_STEPS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_valid(s_axis_tvalid),
		.s_op(s_axis_tuser),
		.s_idx(s_axis_tdata[5:0]),
		.s_ready(s_axis_tready),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg_ready(cfg_ready),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.sts(sts),
		.cmd(cmd),
		.ctl(ctl)
	);

	pdu_datapath #(.POS_FRAC_BITS(POS_FRAC_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.ctl(ctl),
		.in_data(s_axis_tdata),
		.sts(sts),
		.out_data(m_axis_tdata)
	);

endmodule

@@ tb/sv/tb_periodic_displacement_unit.sv @@
// Testbench of periodic_displacement_unit: loads cell tables, sweeps the
// registers and checks every result word against a built-in predictor.
// Depends on pdu_pkg and the periodic_displacement_unit RTL.
module tb_periodic_displacement_unit
	import pdu_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  WRAP_BOUND  = 16;
	localparam longint CYCLE_LIMIT = 20000000;
	localparam bit  OP_DISP = 1'b0;
	localparam bit  OP_LOAD = 1'b1;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic [31:0] dx, dy, dz, mag;
		logic        hit, sat;
	} disp_t;

	class disp_scoreboard;
		logic [31:0] coef [NUM_COEF];
		bit          min_image;
		logic [2:0]  pbc;
		logic [1:0]  mode;
		disp_t       pending_q [$];
		int          errors;

		function new();
			min_image = 1'b1;
			pbc = 3'd7;
			mode = MODE_DIRECT;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [2:0] val);
			case (idx)
				REG_USE_MIN_IMAGE: min_image = val[0];
				REG_PBC_MASK:      pbc = val;
				REG_MAPPING_MODE:  mode = val[1:0];
				default: ;
			endcase
		endfunction

		function longint cw(int slot);
			return longint'(signed'(coef[slot]));
		endfunction

		function longint reduced(int base, int row, longint p [3]);
			longint acc;
			acc = cw(base + row * 4 + 3) <<< 8;
			for (int c = 0; c < 3; c++)
				acc += (cw(base + row * 4 + c) * p[c]) >>> 8;
			return acc;
		endfunction

		function logic [31:0] clamp(wide_t v, inout bit sat);
			if (v > 128'sd2147483647) begin
				sat = 1'b1;
				return 32'h7FFF_FFFF;
			end
			if (v < -128'sd2147483648) begin
				sat = 1'b1;
				return 32'h8000_0000;
			end
			return v[31:0];
		endfunction

		function bit shortens(longint u [3], longint c [3], longint sgn);
			wide_t acc, a, b;
			acc = 0;
			for (int i = 0; i < 3; i++) begin
				a = u[i];
				b = 2 * sgn * c[i];
				acc += a * b;
				a = c[i];
				acc += a * a;
			end
			return acc < 0;
		endfunction

		function logic [31:0] root(logic [63:0] v);
			logic [63:0] r, b;
			r = 0;
			b = 64'h4000_0000_0000_0000;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r[31:0];
		endfunction

		function void note_word(bit op, logic [231:0] d);
			longint pc [3], pr [3], u [3], c [3], dv [3];
			logic [31:0] res [3];
			logic [63:0] t, sq;
			wide_t acc, a, b;
			bit sat, hit;
			int back, steps;
			disp_t e;
			if (op == OP_LOAD) begin
				if (d[5:0] < NUM_COEF)
					coef[d[5:0]] = d[37:6];
				return;
			end
			sat = 0;
			hit = 0;
			for (int k = 0; k < 3; k++) begin
				pc[k] = longint'(signed'(d[38 + 32 * k +: 32]));
				pr[k] = longint'(signed'(d[134 + 32 * k +: 32]));
			end
			if (mode != MODE_DIRECT) begin
				back = (mode == MODE_REF) ? REF_MAT : CUR_MAT;
				for (int k = 0; k < 3; k++) begin
					dv[k] = reduced(CUR_INV, k, pc) - reduced(REF_INV, k, pr);
					if (min_image && pbc[k]) begin
						t = (dv[k] + 64'h8000_0000) & 64'hFFFF_FFFF;
						dv[k] = longint'(t) - 64'sh8000_0000;
					end
				end
				for (int k = 0; k < 3; k++) begin
					acc = 0;
					for (int i = 0; i < 3; i++) begin
						a = dv[i];
						b = cw(back + k * 4 + i);
						acc += a * b;
					end
					res[k] = clamp(acc >>> 40, sat);
				end
			end else begin
				for (int k = 0; k < 3; k++)
					u[k] = pc[k] - pr[k];
				if (min_image) begin
					for (int k = 0; k < 3; k++) begin
						if (!pbc[k])
							continue;
						steps = 0;
						for (int i = 0; i < 3; i++)
							c[i] = cw(REF_MAT + i * 4 + k) >>> 8;
						while (shortens(u, c, 1)) begin
							if (steps >= WRAP_BOUND) begin
								hit = 1;
								break;
							end
							for (int i = 0; i < 3; i++)
								u[i] += c[i];
							steps++;
						end
						while (shortens(u, c, -1)) begin
							if (steps >= WRAP_BOUND) begin
								hit = 1;
								break;
							end
							for (int i = 0; i < 3; i++)
								u[i] -= c[i];
							steps++;
						end
					end
				end
				for (int k = 0; k < 3; k++) begin
					a = u[k];
					res[k] = clamp(a, sat);
				end
			end
			sq = 0;
			for (int k = 0; k < 3; k++) begin
				t = signed'(res[k]) < 0 ? -longint'(signed'(res[k])) : longint'(signed'(res[k]));
				sq += t * t;
			end
			e.dx = res[0];
			e.dy = res[1];
			e.dz = res[2];
			e.mag = root(sq);
			e.hit = hit;
			e.sat = sat;
			pending_q.push_back(e);
		endfunction

		function void check_word(logic [135:0] d);
			disp_t e;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word %h", d);
				return;
			end
			e = pending_q.pop_front();
			if (d[31:0] !== e.dx || d[63:32] !== e.dy || d[95:64] !== e.dz ||
					d[127:96] !== e.mag || d[128] !== e.hit || d[129] !== e.sat) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp x %h y %h z %h mag %h hit %b sat %b, got %h %h %h %h %b %b",
						e.dx, e.dy, e.dz, e.mag, e.hit, e.sat,
						d[31:0], d[63:32], d[95:64], d[127:96], d[128], d[129]);
			end
		endfunction
	endclass

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [231:0] s_axis_tdata = '0;
	logic         s_axis_tuser = 0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [135:0] m_axis_tdata;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [2:0]   cfg_data = '0;

	disp_scoreboard sb = new();
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	longint cycles = 0;

	periodic_displacement_unit dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata);
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_word(bit op, logic [231:0] d);
		if ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= d;
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(op, d);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [2:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coef(int slot);
		int col, row;
		col = slot % 4;
		row = (slot % 12) / 4;
		if ($urandom_range(9) == 0)
			return $urandom;
		if (col == 3)
			return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
		if (slot >= CUR_INV && slot < REF_MAT || slot >= REF_INV) begin
			if (row == col)
				return $urandom_range(32'h0008_0000, 32'h0080_0000);
			return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
		end
		if (row == col)
			return $urandom_range(32'h0200_0000, 32'h1400_0000);
		return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
	endfunction

	function automatic logic [31:0] rand_pos();
		if ($urandom_range(99) < 15)
			return $urandom;
		return $urandom_range(0, 32'h0190_0000) - 32'h00C8_0000;
	endfunction

	function automatic logic [231:0] disp_word(logic [31:0] p [6]);
		logic [231:0] d;
		d = {$urandom, $urandom};
		d[231:230] = 2'b00;
		for (int k = 0; k < 6; k++)
			d[38 + 32 * k +: 32] = p[k];
		return d;
	endfunction

	task automatic send_disp();
		logic [31:0] p [6];
		for (int k = 0; k < 6; k++)
			p[k] = rand_pos();
		send_word(OP_DISP, disp_word(p));
	endtask

	task automatic send_load(logic [5:0] idx, logic [31:0] val);
		logic [231:0] d;
		d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		d[231:230] = 2'b00;
		d[5:0] = idx;
		d[37:6] = val;
		send_word(OP_LOAD, d);
	endtask

	task automatic load_cells();
		for (int i = 0; i < NUM_COEF; i++)
			send_load(i[5:0], rand_coef(i));
	endtask

	task automatic directed_disps();
		logic [31:0] p [6];
		for (int k = 0; k < 6; k++)
			p[k] = 0;
		send_word(OP_DISP, disp_word(p));
		for (int k = 0; k < 6; k++)
			p[k] = (k < 3) ? 32'h7FFF_FFFF : 32'h8000_0000;
		send_word(OP_DISP, disp_word(p));
		for (int k = 0; k < 6; k++)
			p[k] = (k < 3) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		send_word(OP_DISP, disp_word(p));
		for (int k = 0; k < 6; k++)
			p[k] = (k < 3) ? 32'h0010_0000 : 32'hFFF0_0000;
		send_word(OP_DISP, disp_word(p));
	endtask

	logic [2:0] phase_cfg [9][3] = '{
		'{1, 7, 0}, '{1, 7, 1}, '{1, 7, 2}, '{0, 7, 0}, '{1, 5, 1},
		'{0, 2, 2}, '{1, 3, 3}, '{1, 0, 0}, '{1, 6, 0}};

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		load_cells();
		send_load(6'd63, $urandom);
		send_load(6'd48, $urandom);
		directed_disps();
		for (int ph = 0; ph < 9; ph++) begin
			drain();
			write_reg(REG_USE_MIN_IMAGE, phase_cfg[ph][0]);
			write_reg(REG_PBC_MASK, phase_cfg[ph][1]);
			write_reg(REG_MAPPING_MODE, phase_cfg[ph][2]);
			if (ph == 4)
				write_reg(2'd3, 3'd5);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 67;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 67;
				end
				default: begin
					send_idle_pct = 38;
					recv_stall_pct = 38;
				end
			endcase
			if (ph % 3 == 2)
				load_cells();
			directed_disps();
			for (int n = 0; n < 124; n++) begin
				case ($urandom_range(19))
					0, 1: send_load(6'($urandom_range(0, NUM_COEF - 1)),
						rand_coef($urandom_range(0, NUM_COEF - 1)));
					2: send_load(6'($urandom_range(NUM_COEF, 63)), $urandom);
					default: send_disp();
				endcase
			end
		end
		drain();
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

@@ files.f @@
hdl/pdu_pkg.sv
hdl/pdu_ram.sv
hdl/pdu_datapath.sv
hdl/pdu_ctrl.sv
hdl/periodic_displacement_unit.sv
tb/sv/tb_periodic_displacement_unit.sv
